// ===== rtl/core/mkd_pkg.sv =====
// package for the morse key timing decoder: field widths, register indexes,
// channel structs and the morse character table
// no dependencies
package mkd_pkg;

  localparam int unsigned TICKS_W = 16;
  localparam int unsigned MS_W    = 13;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned SYM_W   = 5;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned IDX_W   = 2;

  // ticks of 64 us to ms: floor(ticks * 0.064) as a multiply by 0.064 * 2^24, rounded up
  localparam int unsigned     MS_SHIFT = 24;
  localparam int unsigned     MS_MUL_W = 21;
  localparam logic [MS_MUL_W-1:0] MS_MUL = 21'd1073742;

  // largest symbol count that still fits the code tree
  localparam logic [CNT_W-1:0] MAX_SYMBOLS = 3'd5;

  localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 7'h3F;  // '?'
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'h0A;

  // item kinds carried on the input tuser
  localparam logic OP_EDGE     = 1'b0;
  localparam logic OP_OVERFLOW = 1'b1;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_DOT_LIMIT = 2'd0,
    CFG_GAP_LIMIT = 2'd1,
    CFG_DEBOUNCE  = 2'd2
  } mkd_cfg_idx_t;

  typedef struct packed {
    logic [MS_W-1:0] dot_limit;
    logic [MS_W-1:0] gap_limit;
    logic [MS_W-1:0] debounce;
  } mkd_cfg_t;

  // one key event after scaling to ms
  typedef struct packed {
    logic            op;
    logic [MS_W-1:0] iv;
    logic            released;
  } mkd_item_t;

  typedef struct packed {
    logic              char_valid;
    logic [CHAR_W-1:0] char_code;
    logic              dot_led;
    logic              dash_led;
  } mkd_result_t;

  // codes of length n start at 2^n - 2, first symbol is the msb of the key, dash is one
  localparam int unsigned TABLE_N = 62;
  localparam logic [CHAR_W-1:0] CODE_TABLE [TABLE_N] = '{
    // one symbol: E T
    7'h45, 7'h54,
    // two: I A N M
    7'h49, 7'h41, 7'h4E, 7'h4D,
    // three: S U R W D K G O
    7'h53, 7'h55, 7'h52, 7'h57, 7'h44, 7'h4B, 7'h47, 7'h4F,
    // four: H V F ? L ? P J B X C Y Z Q ? ?
    7'h48, 7'h56, 7'h46, 7'h3F, 7'h4C, 7'h3F, 7'h50, 7'h4A,
    7'h42, 7'h58, 7'h43, 7'h59, 7'h5A, 7'h51, 7'h3F, 7'h3F,
    // five: digits only
    7'h35, 7'h34, 7'h3F, 7'h33, 7'h3F, 7'h3F, 7'h3F, 7'h32,
    7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h31,
    7'h36, 7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h3F,
    7'h37, 7'h3F, 7'h3F, 7'h3F, 7'h38, 7'h3F, 7'h39, 7'h30
  };

endpackage

// ===== rtl/core/mkd_interval.sv =====
// timer capture to milliseconds: floor(ticks * 64 / 1000) by reciprocal multiply
// depends on mkd_pkg
module mkd_interval (
  input  logic [mkd_pkg::TICKS_W-1:0] ticks,
  output logic [mkd_pkg::MS_W-1:0]    iv
);

  logic [mkd_pkg::TICKS_W+mkd_pkg::MS_MUL_W-1:0] prod;

  // rounding error stays below the smallest distance to the next whole ms
  assign prod = {{mkd_pkg::MS_MUL_W{1'b0}}, ticks} *
                {{mkd_pkg::TICKS_W{1'b0}}, mkd_pkg::MS_MUL};
  assign iv   = prod[mkd_pkg::MS_SHIFT +: mkd_pkg::MS_W];

endmodule

// ===== rtl/core/mkd_char_rom.sv =====
// morse sequence to ascii lookup
// depends on mkd_pkg
module mkd_char_rom (
  input  logic [mkd_pkg::CNT_W-1:0]  count,
  input  logic [mkd_pkg::SYM_W-1:0]  bits,
  output logic [mkd_pkg::CHAR_W-1:0] char_code
);

  logic [5:0] key;
  logic [5:0] base;

  // reverse the stored symbols so the first one lands in the msb
  always_comb begin
    key  = '0;
    base = '0;
    case (count)
      3'd1: begin
        key  = {5'd0, bits[0]};
        base = 6'd0;
      end
      3'd2: begin
        key  = {4'd0, bits[0], bits[1]};
        base = 6'd2;
      end
      3'd3: begin
        key  = {3'd0, bits[0], bits[1], bits[2]};
        base = 6'd6;
      end
      3'd4: begin
        key  = {2'd0, bits[0], bits[1], bits[2], bits[3]};
        base = 6'd14;
      end
      3'd5: begin
        key  = {1'd0, bits[0], bits[1], bits[2], bits[3], bits[4]};
        base = 6'd30;
      end
      default: begin
        key  = '0;
        base = '0;
      end
    endcase
  end

  // empty sequence gives a newline, overlong gives unknown
  always_comb begin
    if (count == '0) begin
      char_code = mkd_pkg::CHAR_NEWLINE;
    end else if (count > mkd_pkg::MAX_SYMBOLS) begin
      char_code = mkd_pkg::CHAR_UNKNOWN;
    end else begin
      char_code = mkd_pkg::CODE_TABLE[base + key];
    end
  end

endmodule

// ===== rtl/core/mkd_engine.sv =====
// decoder state and per-event decisions: debounce, dot or dash, character end
// depends on mkd_pkg and mkd_char_rom
module mkd_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  mkd_pkg::mkd_item_t  item,
  input  mkd_pkg::mkd_cfg_t   cfg,
  output mkd_pkg::mkd_result_t result
);

  logic [mkd_pkg::MS_W-1:0]   prev_iv_r, prev_iv_nxt;
  logic                       ovf_r, ovf_nxt;
  logic [mkd_pkg::CNT_W-1:0]  cnt_r, cnt_nxt, cnt_w;
  logic [mkd_pkg::SYM_W-1:0]  bits_r, bits_nxt, bits_w;
  logic                       dot_r, dot_nxt;
  logic                       dash_r, dash_nxt;
  logic [mkd_pkg::MS_W-1:0]   diff;
  logic                       edge_ok;
  logic                       is_dash;
  logic                       emit;
  logic [mkd_pkg::CHAR_W-1:0] rom_char;

  mkd_char_rom u_rom (
    .count     (cnt_w),
    .bits      (bits_w),
    .char_code (rom_char)
  );

  // distance from the previous interval
  always_comb begin
    if (item.iv > prev_iv_r) begin
      diff = item.iv - prev_iv_r;
    end else begin
      diff = prev_iv_r - item.iv;
    end
  end

  assign edge_ok = (diff > cfg.debounce) || ovf_r;
  assign is_dash = ovf_r || (item.iv >= cfg.dot_limit);

  // next state for one event
  always_comb begin
    prev_iv_nxt = prev_iv_r;
    ovf_nxt     = ovf_r;
    cnt_w       = cnt_r;
    bits_w      = bits_r;
    dot_nxt     = dot_r;
    dash_nxt    = dash_r;
    emit        = 1'b0;
    if (item.op == mkd_pkg::OP_OVERFLOW) begin
      ovf_nxt = 1'b1;
      emit    = item.released && (cnt_r != '0);
    end else begin
      if (edge_ok) begin
        if (item.released) begin
          // release closes a symbol
          dot_nxt  = !is_dash;
          dash_nxt = is_dash;
          if (cnt_r < mkd_pkg::MAX_SYMBOLS) begin
            bits_w[cnt_r] = is_dash;
          end
          cnt_w = cnt_r + 3'd1;
          emit  = (cnt_w >= mkd_pkg::MAX_SYMBOLS);
        end else begin
          // press after a long gap ends the character
          dot_nxt  = 1'b0;
          dash_nxt = 1'b0;
          emit     = (ovf_r && (cnt_r != '0)) || (item.iv > cfg.gap_limit);
        end
        ovf_nxt = 1'b0;
      end
      prev_iv_nxt = item.iv;
    end
  end

  assign cnt_nxt  = emit ? '0 : cnt_w;
  assign bits_nxt = emit ? '0 : bits_w;

  assign result.char_valid = emit;
  assign result.char_code  = emit ? rom_char : '0;
  assign result.dot_led    = dot_nxt;
  assign result.dash_led   = dash_nxt;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_iv_r <= '0;
      ovf_r     <= 1'b0;
      cnt_r     <= '0;
      bits_r    <= '0;
      dot_r     <= 1'b0;
      dash_r    <= 1'b0;
    end else if (step_en) begin
      prev_iv_r <= prev_iv_nxt;
      ovf_r     <= ovf_nxt;
      cnt_r     <= cnt_nxt;
      bits_r    <= bits_nxt;
      dot_r     <= dot_nxt;
      dash_r    <= dash_nxt;
    end
  end

endmodule

// ===== rtl/core/morse_key_timing_decoder.sv =====
// top level of the morse key timing decoder: stream ports, input and result registers
// depends on mkd_pkg, mkd_interval, mkd_engine
//
//  channel | direction | handshake          | payload
//  in_     | sink      | in_tvalid/tready   | tuser op, tdata key event
//  out_    | source    | out_tvalid/tready  | tuser char_valid, tdata char and lamps
//  cfg_    | sink      | cfg_valid/ready    | cfg_index, cfg_data (always ready)
//
// one event per cycle while the result is not stalled; an event passes the input register and then the result register
// the ms scaling multiply sits before the input register, the decision and table
// lookup between the input register and the result register
// a stalled result holds the pipe; the input register still fills while the
// result waits, so one extra request is taken before in_tready drops
// reset clears all control and decoder state and loads the register defaults
module morse_key_timing_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // [0] op
  input  logic [23:0] in_tdata,   // [15:0] capture_ticks, [16] key_released, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tuser,  // [0] char_valid
  output logic [15:0] out_tdata,  // [6:0] char_code, [7] dot_led, [8] dash_led, rest zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  logic                     in_vld_r;
  mkd_pkg::mkd_item_t       item_r;
  logic [mkd_pkg::MS_W-1:0] iv;
  mkd_pkg::mkd_cfg_t        cfg_r;
  mkd_pkg::mkd_result_t     result;
  mkd_pkg::mkd_result_t     res_r;
  logic                     out_vld_r;
  logic                     advance;
  logic                     fire;
  logic                     in_take;

  mkd_interval u_interval (
    .ticks (in_tdata[mkd_pkg::TICKS_W-1:0]),
    .iv    (iv)
  );

  mkd_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (fire),
    .item    (item_r),
    .cfg     (cfg_r),
    .result  (result)
  );

  // pipe control
  assign advance   = !out_vld_r || out_tready;
  assign fire      = in_vld_r && advance;
  assign in_tready = !in_vld_r || advance;
  assign in_take   = in_tvalid && in_tready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.op       <= in_tuser;
      item_r.iv       <= iv;
      item_r.released <= in_tdata[mkd_pkg::TICKS_W];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= result;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = res_r.char_valid;
  assign out_tdata  = {7'd0, res_r.dash_led, res_r.dot_led, res_r.char_code};

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dot_limit <= 13'd400;
      cfg_r.gap_limit <= 13'd400;
      cfg_r.debounce  <= 13'd5;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mkd_pkg::CFG_DOT_LIMIT: cfg_r.dot_limit <= cfg_data;
        mkd_pkg::CFG_GAP_LIMIT: cfg_r.gap_limit <= cfg_data;
        mkd_pkg::CFG_DEBOUNCE:  cfg_r.debounce  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/mkd_checker.sv =====
// port-level checks for the morse key timing decoder, bound to the top level
// depends on morse_key_timing_decoder
module mkd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic        out_tuser,
  input logic [15:0] out_tdata
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // no character code without a character
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[6:0] == 7'd0)
    else $error("character code set without char_valid");

  // dot and dash lamps are never lit together
  a_lamps: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[7] && out_tdata[8]))
    else $error("both lamps lit");

  // an empty result side always leaves room for a request
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

endmodule

bind morse_key_timing_decoder mkd_checker u_mkd_checker (.*);
